// ----- rtl/flood_duplicate_hop_filter_unit_macros.svh -----
// assertion macros for the flood duplicate hop filter checker
// no dependencies; expects clk and rst in the scope of use
`ifndef FLOOD_DUPLICATE_HOP_FILTER_UNIT_MACROS_SVH
`define FLOOD_DUPLICATE_HOP_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FDHF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdhf assertion failed");

// next-cycle implication, disabled in reset
`define FDHF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdhf assertion failed");

`endif

// ----- rtl/fdhf_pkg.sv -----
// shared types and constants of the flood duplicate hop filter
// no dependencies
package fdhf_pkg;

  localparam int FDHF_KEY_W = 24;
  localparam int FDHF_DEPTH_DEFAULT = 16;
  localparam logic [7:0] MAX_HOPS_RESET = 8'd3;
  localparam logic [7:0] HOP_MAX = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_FORWARD   = 2'd0,
    VERDICT_HOP_LIMIT = 2'd1,
    VERDICT_DUPLICATE = 2'd2
  } verdict_t;

  // requests from the sequencer to the history store
  typedef struct packed {
    logic rd_en;
    logic ins_en;
  } hist_req_t;

  // registered read data of the history store
  typedef struct packed {
    logic                  valid;
    logic [FDHF_KEY_W-1:0] key;
  } hist_rsp_t;

  typedef struct packed {
    logic     forward;
    verdict_t verdict;
    logic [7:0] next_hop_count;
  } result_t;

endpackage

// ----- rtl/flood_duplicate_hop_filter_unit.sv -----
// duplicate and hop-limit filter for a flooding node: top level
// depends on fdhf_pkg, fdhf_ctrl and fdhf_hist
//
// Each input transaction carries the id of the neighbor that delivered a flood
// packet, the packet version and its hop count; each produces exactly one
// result transaction. A packet whose hop count is at or above max_hops is
// dropped with verdict 1 and is not recorded. Otherwise the (sender_id,
// packet_version) pair is looked up in a history of HISTORY_DEPTH entries;
// a match drops the packet with verdict 2. A new pair is written into the
// history, which behaves as a fifo and overwrites its oldest entry when full,
// and the packet is forwarded with hop count plus one (saturating at 255).
// Dropped results show forward 0 and next_hop_count 0. The history is keyed
// on the immediate sender, not the origin, and is empty after reset (its
// valid bits clear at once, so there is no clearing pass).
// Flow: one transaction at a time. A forwarded packet is checked, scanned
// against the whole history and inserted before its result is formed; a
// duplicate ends as soon as its match is seen, and a hop-limit drop skips
// the scan. The single key comparator walks the history one entry per cycle
// behind the registered read port of the history memory. The result sits
// in an output register, so the next packet is taken while the result still
// waits on out_stall. max_hops (reset value 3) is written through cfg_wr_en
// and cfg_wr_data; the user must write it only while the block is idle, as the block does not enforce this.
module flood_duplicate_hop_filter_unit #(
  parameter int HISTORY_DEPTH = fdhf_pkg::FDHF_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input transaction
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sender_id,
  input  logic [15:0] packet_version,
  input  logic [7:0]  hop_count,
  // result transaction
  output logic        out_valid,
  input  logic        out_stall,
  output logic        forward,
  output logic [1:0]  verdict,
  output logic [7:0]  next_hop_count
);
  import fdhf_pkg::*;

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [7:0] max_hops;
  hist_req_t req;
  hist_rsp_t rsp;
  logic [IDX_W-1:0] rd_addr;
  logic [FDHF_KEY_W-1:0] key;
  logic res_free;
  logic res_load;
  result_t res;

  // hop limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_hops <= MAX_HOPS_RESET;
    end else if (cfg_wr_en) begin
      max_hops <= cfg_wr_data;
    end
  end

  // output register frees when empty or when its transaction is taken
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      forward        <= res.forward;
      verdict        <= res.verdict;
      next_hop_count <= res.next_hop_count;
    end
  end

  fdhf_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sender_id     (sender_id),
    .packet_version(packet_version),
    .hop_count     (hop_count),
    .max_hops      (max_hops),
    .req           (req),
    .rd_addr       (rd_addr),
    .key           (key),
    .rsp           (rsp),
    .res_free      (res_free),
    .res_load      (res_load),
    .res           (res)
  );

  fdhf_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .IDX_W        (IDX_W)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rd_addr(rd_addr),
    .wr_key (key),
    .rsp    (rsp)
  );

endmodule

// ----- rtl/fdhf_hist.sv -----
// history store: key memory, valid bits and fifo pointers
// depends on fdhf_pkg
module fdhf_hist #(
  parameter int HISTORY_DEPTH = fdhf_pkg::FDHF_DEPTH_DEFAULT,
  parameter int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fdhf_pkg::hist_req_t             req,
  input  logic [IDX_W-1:0]                rd_addr,
  input  logic [fdhf_pkg::FDHF_KEY_W-1:0] wr_key,
  output fdhf_pkg::hist_rsp_t             rsp
);
  import fdhf_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [FDHF_KEY_W-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] oldest_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [SUM_W-1:0] sum;
  logic [IDX_W-1:0] slot;
  logic full;

  assign full = (fill == CNT_W'(HISTORY_DEPTH));
  assign sum  = SUM_W'(oldest) + SUM_W'(fill);

  always_comb begin
    // oldest < depth and fill < depth when not full, so one subtract wraps
    if (full) begin
      slot = oldest;
    end else if (sum >= SUM_W'(HISTORY_DEPTH)) begin
      slot = IDX_W'(sum - SUM_W'(HISTORY_DEPTH));
    end else begin
      slot = IDX_W'(sum);
    end
    oldest_next = oldest;
    fill_next   = fill;
    if (req.ins_en) begin
      if (full) begin
        oldest_next = (oldest == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest + 1'b1;
      end else begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      oldest <= '0;
      fill   <= '0;
    end else begin
      oldest <= oldest_next;
      fill   <= fill_next;
      if (req.ins_en) begin
        vld[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ins_en) begin
      mem[slot] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.key   <= mem[rd_addr];
      rsp.valid <= vld[rd_addr];
    end
  end

endmodule

// ----- rtl/fdhf_ctrl.sv -----
// sequencer with the shared key comparator; walks the history one entry a cycle
// depends on fdhf_pkg
module fdhf_ctrl #(
  parameter int HISTORY_DEPTH = fdhf_pkg::FDHF_DEPTH_DEFAULT,
  parameter int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      sender_id,
  input  logic [15:0]                     packet_version,
  input  logic [7:0]                      hop_count,
  input  logic [7:0]                      max_hops,
  output fdhf_pkg::hist_req_t             req,
  output logic [IDX_W-1:0]                rd_addr,
  output logic [fdhf_pkg::FDHF_KEY_W-1:0] key,
  input  fdhf_pkg::hist_rsp_t             rsp,
  input  logic                            res_free,
  output logic                            res_load,
  output fdhf_pkg::result_t               res
);
  import fdhf_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_INSERT = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic pend;
  logic pend_next;
  logic [7:0] hops;
  logic issue;
  logic hit;
  result_t res_next;

  assign in_stall = (state != S_IDLE);
  assign issue    = (state == S_SCAN) && (cnt != CNT_W'(HISTORY_DEPTH));
  assign rd_addr  = cnt[IDX_W-1:0];
  // the one shared compare: stored key against the transaction key
  assign hit      = pend && rsp.valid && (rsp.key == key);
  assign res_load = (state == S_RESP) && res_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pend_next  = 1'b0;
    res_next   = res;
    req.rd_en  = 1'b0;
    req.ins_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_next = '0;
        if (hops >= max_hops) begin
          res_next   = '{forward: 1'b0, verdict: VERDICT_HOP_LIMIT, next_hop_count: 8'd0};
          state_next = S_RESP;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        req.rd_en = issue;
        pend_next = issue;
        if (issue) begin
          cnt_next = cnt + 1'b1;
        end
        if (hit) begin
          res_next   = '{forward: 1'b0, verdict: VERDICT_DUPLICATE, next_hop_count: 8'd0};
          state_next = S_RESP;
        end else if (!issue && !pend) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        req.ins_en = 1'b1;
        res_next   = '{forward: 1'b1, verdict: VERDICT_FORWARD,
                       next_hop_count: (hops == HOP_MAX) ? HOP_MAX : hops + 8'd1};
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if ((state == S_IDLE) && in_valid) begin
      key  <= {sender_id, packet_version};
      hops <= hop_count;
    end
  end

endmodule

// ----- rtl/fdhf_checker.sv -----
// port-level checker for the flood duplicate hop filter, bound to the top level
// depends on fdhf_pkg and flood_duplicate_hop_filter_unit_macros.svh
`include "flood_duplicate_hop_filter_unit_macros.svh"

module fdhf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        forward,
  input logic [1:0]  verdict,
  input logic [7:0]  next_hop_count
);
  import fdhf_pkg::*;

  // a stalled result stays offered
  `FDHF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // forward flag agrees with the verdict
  `FDHF_ASSERT_SAME(a_fwd_verdict, out_valid, forward == (verdict == VERDICT_FORWARD))
  // dropped packets carry a zero hop count
  `FDHF_ASSERT_SAME(a_drop_zero, out_valid && !forward, next_hop_count == 8'd0)
  // one transaction at a time: busy right after an acceptance
  `FDHF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind flood_duplicate_hop_filter_unit fdhf_checker u_fdhf_checker (.*);
